@@ rtl/core/word_break_segmentation_check_defines.svh @@
// Assertion macros shared by the word-break checker RTL.
`ifndef WORD_BREAK_SEGMENTATION_CHECK_DEFINES_SVH
`define WORD_BREAK_SEGMENTATION_CHECK_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WBSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WBSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/wbsc_pkg.sv @@
package wbsc_pkg;

  localparam int CHAR_W      = 8;
  localparam int MODE_W      = 2;
  localparam int TDATA_IN_W  = 8;
  localparam int TUSER_IN_W  = 2;
  localparam int TDATA_OUT_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_DICT  = 2'd0,
    MODE_TEXT  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic              store;
    logic              clear;
    logic              fin;
    logic [CHAR_W-1:0] ch;
  } dict_cmd_t;

endpackage

@@ rtl/core/wbsc_dict.sv @@
module wbsc_dict #(
  parameter int DICT_WORDS   = 64,
  parameter int MAX_WORD_LEN = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  wbsc_pkg::dict_cmd_t                       cmd_i,
  input  logic                                      rd_en_i,
  input  logic [((DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1)-1:0] rd_addr_i,
  output logic [$clog2(MAX_WORD_LEN+1)-1:0]         rd_len_o,
  output logic [MAX_WORD_LEN*wbsc_pkg::CHAR_W-1:0]  rd_chars_o,
  output logic [$clog2(DICT_WORDS+1)-1:0]           word_count_o,
  output logic                                      dropped_o
);
  import wbsc_pkg::*;

  localparam int LW      = $clog2(MAX_WORD_LEN + 1);
  localparam int CW      = $clog2(DICT_WORDS + 1);
  localparam int AW      = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
  localparam int ROW_W   = MAX_WORD_LEN * CHAR_W;
  localparam int ENTRY_W = LW + ROW_W;

  logic [CHAR_W-1:0]  build_q [MAX_WORD_LEN];
  logic [CHAR_W-1:0]  build_d [MAX_WORD_LEN];
  logic [LW-1:0]      build_len_q, build_len_d;
  logic               too_long_q, too_long_d;
  logic [CW-1:0]      count_q, count_d;
  logic               dropped_q, dropped_d;
  logic               room;
  logic               wr_en;
  logic [ROW_W-1:0]   wr_row;
  logic [LW-1:0]      wr_len;
  logic [ENTRY_W-1:0] mem_q [DICT_WORDS];
  logic [ENTRY_W-1:0] rd_q;

  // Newest byte sits at slot 0, so slot k lines up with text window slot k.
  always_comb begin
    room        = (build_len_q < LW'(MAX_WORD_LEN));
    build_d     = build_q;
    build_len_d = build_len_q;
    too_long_d  = too_long_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    wr_en       = 1'b0;
    wr_len      = build_len_q + LW'(1);
    if (cmd_i.store) begin
      if (room) begin
        for (int k = MAX_WORD_LEN - 1; k > 0; k--) begin
          build_d[k] = build_q[k-1];
        end
        build_d[0]  = cmd_i.ch;
        build_len_d = build_len_q + LW'(1);
      end else begin
        too_long_d = 1'b1;
      end
      if (cmd_i.fin) begin
        if (too_long_q || !room || (count_q == CW'(DICT_WORDS))) begin
          dropped_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
        end
        build_len_d = '0;
        too_long_d  = 1'b0;
      end
    end
    if (cmd_i.clear) begin
      build_len_d = '0;
      too_long_d  = 1'b0;
      count_d     = '0;
      dropped_d   = 1'b0;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      wr_row[k*CHAR_W +: CHAR_W] = build_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      build_len_q <= '0;
      too_long_q  <= 1'b0;
      count_q     <= '0;
      dropped_q   <= 1'b0;
    end else begin
      build_len_q <= build_len_d;
      too_long_q  <= too_long_d;
      count_q     <= count_d;
      dropped_q   <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    build_q <= build_d;
  end

  // Word table: one row per word, length beside its bytes.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= {wr_len, wr_row};
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_len_o     = rd_q[ENTRY_W-1 -: LW];
  assign rd_chars_o   = rd_q[ROW_W-1:0];
  assign word_count_o = count_q;
  assign dropped_o    = dropped_q;

endmodule

@@ rtl/core/wbsc_word_cmp.sv @@
module wbsc_word_cmp #(
  parameter int MAX_WORD_LEN = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     clear_i,
  input  logic                                     valid_i,
  input  logic [MAX_WORD_LEN*wbsc_pkg::CHAR_W-1:0] win_i,
  input  logic [MAX_WORD_LEN*wbsc_pkg::CHAR_W-1:0] chars_i,
  input  logic [$clog2(MAX_WORD_LEN+1)-1:0]        len_i,
  input  logic [MAX_WORD_LEN:0]                    reach_i,
  output logic                                     hit_o
);
  import wbsc_pkg::*;

  localparam int LW = $clog2(MAX_WORD_LEN + 1);

  logic [MAX_WORD_LEN-1:0] slot_ok;
  logic                    reach_sel;
  logic                    match;
  logic                    hit_q;

  // Slots past the word length are don't-care.
  always_comb begin
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      slot_ok[k] = (chars_i[k*CHAR_W +: CHAR_W] == win_i[k*CHAR_W +: CHAR_W])
                   || (LW'(k) >= len_i);
    end
    reach_sel = (len_i != '0) ? reach_i[len_i - LW'(1)] : 1'b0;
    match     = (len_i != '0) && reach_sel && (&slot_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (clear_i) begin
      hit_q <= 1'b0;
    end else if (valid_i && match) begin
      hit_q <= 1'b1;
    end
  end

  assign hit_o = hit_q;

endmodule

@@ rtl/core/word_break_segmentation_check.sv @@
// Word-break checker: tells whether a streamed text splits into a sequence of
// dictionary words, each word usable any number of times. Load words with
// tuser = 0, one byte per transaction, tlast on the final byte; words longer
// than MAX_WORD_LEN bytes, or ending while DICT_WORDS words are already
// stored, are dropped and raise the status bit until the next clear. Stream
// text with tuser = 1, tlast on the final byte; that transaction yields one
// result transaction with breakable in tdata bit 0 and status in bit 1, and
// the text state restarts while the dictionary stays. tuser = 2 clears the
// dictionary, the text and the status bit; tuser = 3 is ignored. For a text
// byte the stored words are read from the word table one per cycle through
// its single read port and checked by one comparator. The next item is taken
// while a finished result still waits on the master side; a further final
// text byte holds until that result is taken.
`include "word_break_segmentation_check_defines.svh"

module word_break_segmentation_check #(
  parameter int DICT_WORDS   = 64,
  parameter int MAX_WORD_LEN = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [wbsc_pkg::TDATA_IN_W-1:0]     s_axis_tdata,   // [7:0] ch
  input  logic [wbsc_pkg::TUSER_IN_W-1:0]     s_axis_tuser,   // [1:0] mode
  input  logic                                s_axis_tlast,   // last byte of word or text
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [wbsc_pkg::TDATA_OUT_W-1:0]    m_axis_tdata    // [0] breakable, [1] status,
                                                              // [7:2] zero
);
  import wbsc_pkg::*;

  localparam int LW    = $clog2(MAX_WORD_LEN + 1);
  localparam int CW    = $clog2(DICT_WORDS + 1);
  localparam int AW    = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
  localparam int ROW_W = MAX_WORD_LEN * CHAR_W;

  state_e            state_q, state_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              rd_en;
  logic              rd_vld_q;
  logic              last_q;
  logic              accept;
  mode_e             mode;
  logic              text_go;
  logic              clear_go;
  dict_cmd_t         dict_cmd;
  logic [LW-1:0]     rd_len;
  logic [ROW_W-1:0]  rd_chars;
  logic [CW-1:0]     word_count;
  logic              dropped;
  logic              hit;
  logic              cmp_clear;
  logic              out_load;
  logic              reach_shift;
  logic              text_restart;
  logic [CHAR_W-1:0] window_q [MAX_WORD_LEN];
  logic [ROW_W-1:0]  win_flat;
  logic [MAX_WORD_LEN:0] reach_q;
  logic              m_valid_q;
  logic              m_break_q;
  logic              m_status_q;

  // Input side: take an item only while no text byte is being scanned.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mode          = mode_e'(s_axis_tuser);
  assign text_go       = accept && (mode == MODE_TEXT);
  assign clear_go      = accept && (mode == MODE_CLEAR);

  always_comb begin
    dict_cmd.store = accept && (mode == MODE_DICT);
    dict_cmd.clear = clear_go;
    dict_cmd.fin   = s_axis_tlast;
    dict_cmd.ch    = s_axis_tdata[CHAR_W-1:0];
  end

  wbsc_dict #(
    .DICT_WORDS   (DICT_WORDS),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_dict (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dict_cmd),
    .rd_en_i      (rd_en),
    .rd_addr_i    (idx_q[AW-1:0]),
    .rd_len_o     (rd_len),
    .rd_chars_o   (rd_chars),
    .word_count_o (word_count),
    .dropped_o    (dropped)
  );

  always_comb begin
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      win_flat[k*CHAR_W +: CHAR_W] = window_q[k];
    end
  end

  // One word per cycle: read data is registered and arrives the cycle after its address.
  wbsc_word_cmp #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cmp_clear),
    .valid_i (rd_vld_q),
    .win_i   (win_flat),
    .chars_i (rd_chars),
    .len_i   (rd_len),
    .reach_i (reach_q),
    .hit_o   (hit)
  );

  // Sequencer: scan all stored words, then retire the text byte.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    rd_en        = 1'b0;
    cmp_clear    = 1'b0;
    out_load     = 1'b0;
    reach_shift  = 1'b0;
    text_restart = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (text_go) begin
          idx_d     = '0;
          cmp_clear = 1'b1;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q < word_count) begin
          rd_en = 1'b1;
          idx_d = idx_q + CW'(1);
        end else begin
          // Last read's compare lands this cycle.
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!last_q) begin
          reach_shift = 1'b1;
          state_d     = ST_IDLE;
        end else if (!m_valid_q || m_axis_tready) begin
          out_load     = 1'b1;
          text_restart = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_en;
    end
  end

  // Text window: newest byte at slot 0.
  always_ff @(posedge clk_i) begin
    if (text_go) begin
      for (int k = MAX_WORD_LEN - 1; k > 0; k--) begin
        window_q[k] <= window_q[k-1];
      end
      window_q[0] <= s_axis_tdata[CHAR_W-1:0];
      last_q      <= s_axis_tlast;
    end
  end

  // Reach bits: slot k tells whether the prefix k bytes back is reachable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q <= (MAX_WORD_LEN+1)'(1);
    end else if (text_restart || clear_go) begin
      reach_q <= (MAX_WORD_LEN+1)'(1);
    end else if (reach_shift) begin
      reach_q <= {reach_q[MAX_WORD_LEN-1:0], hit};
    end
  end

  // Result register: hold until the master side takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_break_q  <= hit;
      m_status_q <= dropped;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(TDATA_OUT_W-2){1'b0}}, m_status_q, m_break_q};

  `WBSC_ASSERT_NOW(a_busy_not_ready, state_q != ST_IDLE, !s_axis_tready,
    "input taken while a text byte is in flight")
  `WBSC_ASSERT_NOW(a_scan_in_range, state_q == ST_SCAN, idx_q <= word_count,
    "scan index ran past the stored word count")
  `WBSC_ASSERT_NEXT(a_text_starts_scan, text_go, state_q == ST_SCAN,
    "accepted text byte did not start a scan")
  `WBSC_ASSERT_NEXT(a_reach_takes_hit, state_q == ST_FINISH && !last_q,
    reach_q[0] == $past(hit), "newest reach bit does not match the scan hit")

endmodule

@@ tb/word_break_tb_pkg.sv @@
package word_break_tb_pkg;

  import wbsc_pkg::*;

  localparam int DICT_WORDS   = 64;
  localparam int MAX_WORD_LEN = 16;

  // tuser code the block skips without a result
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

  class word_break_scoreboard;

    typedef struct packed {
      bit breakable;
      bit status;
    } verdict_t;

    bit [7:0]    word_bytes[DICT_WORDS][MAX_WORD_LEN];
    int unsigned word_len[DICT_WORDS];
    int unsigned word_total;
    int unsigned partial_len;
    bit          partial_overflow;
    bit          lost_word;
    bit [7:0]    window[MAX_WORD_LEN];   // newest text byte at 0
    bit          reach[MAX_WORD_LEN+1];  // newest prefix at 0
    verdict_t    verdicts_due[$];

    int unsigned errors;
    int unsigned verdicts_seen;
    int unsigned breakable_seen;
    int unsigned flagged_seen;

    function new();
      clear_all();
    endfunction

    function void restart_text();
      foreach (window[k]) window[k] = 8'h00;
      foreach (reach[k]) reach[k] = 1'b0;
      reach[0] = 1'b1;
    endfunction

    function void clear_all();
      word_total       = 0;
      partial_len      = 0;
      partial_overflow = 1'b0;
      lost_word        = 1'b0;
      restart_text();
    endfunction

    // Advance the dictionary and text state by one accepted transaction.
    function void note_input(logic [MODE_W-1:0] mode, logic [7:0] ch, logic fin);
      int unsigned len;
      bit          hit;
      bit          match;
      verdict_t    v;
      case (mode)
        MODE_DICT: begin
          if (partial_len < MAX_WORD_LEN) begin
            if (word_total < DICT_WORDS) word_bytes[word_total][partial_len] = ch;
            partial_len++;
          end else begin
            partial_overflow = 1'b1;
          end
          if (fin) begin
            if (partial_overflow || word_total >= DICT_WORDS) begin
              lost_word = 1'b1;
            end else begin
              word_len[word_total] = partial_len;
              word_total++;
            end
            partial_len      = 0;
            partial_overflow = 1'b0;
          end
        end
        MODE_TEXT: begin
          for (int k = MAX_WORD_LEN - 1; k > 0; k--) window[k] = window[k-1];
          window[0] = ch;
          hit = 1'b0;
          for (int w = 0; w < word_total && !hit; w++) begin
            len = word_len[w];
            if (len >= 1 && len <= MAX_WORD_LEN && reach[len-1]) begin
              match = 1'b1;
              for (int k = 0; k < len; k++) begin
                if (word_bytes[w][len-1-k] != window[k]) match = 1'b0;
              end
              hit = match;
            end
          end
          for (int k = MAX_WORD_LEN; k > 0; k--) reach[k] = reach[k-1];
          reach[0] = hit;
          if (fin) begin
            v.breakable = hit;
            v.status    = lost_word;
            verdicts_due.push_back(v);
            restart_text();
          end
        end
        MODE_CLEAR: clear_all();
        default: begin
        end
      endcase
    endfunction

    // Compare one result transaction against the oldest pending verdict.
    function void check_result(logic [TDATA_OUT_W-1:0] td);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        errors++;
        $error("result with no text pending: tdata=0x%02h", td);
        return;
      end
      v = verdicts_due.pop_front();
      verdicts_seen++;
      if (v.breakable) breakable_seen++;
      if (v.status) flagged_seen++;
      if (td[0] !== v.breakable) begin
        errors++;
        $error("breakable: expected %0b, actual %0b", v.breakable, td[0]);
      end
      if (td[1] !== v.status) begin
        errors++;
        $error("status: expected %0b, actual %0b", v.status, td[1]);
      end
      if (td[TDATA_OUT_W-1:2] !== '0) begin
        errors++;
        $error("pad bits: expected 0x0, actual 0x%0h", td[TDATA_OUT_W-1:2]);
      end
    endfunction

  endclass

endpackage

@@ tb/testbench.sv @@
`default_nettype none

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import wbsc_pkg::*;
  import word_break_tb_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;   // [7:0] ch
  logic [TUSER_IN_W-1:0]  s_axis_tuser = '0;   // [1:0] mode
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;        // [0] breakable, [1] status, [7:2] zero

  word_break_scoreboard sb = new();

  // Words the stimulus knows to be stored, used to build breakable texts.
  bit [7:0] vocab[DICT_WORDS][MAX_WORD_LEN];
  int       vocab_len[DICT_WORDS];
  int       vocab_n;

  int items_sent;
  int ignored_sent;
  int phase_count;
  int fill_phases;
  bit source_calm;   // no gaps on the input side for this phase
  bit sink_calm;     // no stalls on the result side for this phase

  word_break_segmentation_check #(
    .DICT_WORDS  (DICT_WORDS),
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Mostly no pause, often a short one, now and then a long one.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one transaction after an optional gap; note it once it is taken.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [7:0] ch,
                           input logic fin);
    int gap;
    gap = source_calm ? 0 : pick_pause();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= mode;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(mode, ch, fin);
    if (mode == MODE_IGNORED) ignored_sent++;
    else items_sent++;
  endtask

  // Drop valid, then hold until every pending verdict has come back.
  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  // Load one dictionary word; remember it when the block should store it.
  task automatic load_word(input int len, input int alpha, input bit wide);
    bit [7:0] c;
    int       slot;
    slot = vocab_n;
    for (int i = 0; i < len; i++) begin
      c = wide ? 8'($urandom_range(0, 255)) : 8'(8'h61 + $urandom_range(0, alpha - 1));
      if (slot < DICT_WORDS && i < MAX_WORD_LEN) vocab[slot][i] = c;
      if (i > 0 && $urandom_range(0, 39) == 0) begin
        send_item(MODE_IGNORED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      send_item(MODE_DICT, c, i == len - 1);
    end
    if (len <= MAX_WORD_LEN && slot < DICT_WORDS) begin
      vocab_len[slot] = len;
      vocab_n++;
    end
  endtask

  // Stream one text: mostly a chain of known words, sometimes damaged,
  // sometimes plain noise; words and ignored codes may slip in between bytes.
  task automatic send_text(input int alpha);
    bit [7:0] text_bytes[64];
    int       n;
    int       pick;
    int       r;
    n = 0;
    r = $urandom_range(0, 99);
    if (vocab_n == 0 || r < 10) begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
        text_bytes[i] = (r < 5) ? 8'($urandom_range(0, 255))
                                : 8'(8'h61 + $urandom_range(0, alpha - 1));
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        pick = $urandom_range(0, vocab_n - 1);
        if (n + vocab_len[pick] > 48) break;
        for (int k = 0; k < vocab_len[pick]; k++) begin
          text_bytes[n] = vocab[pick][k];
          n++;
        end
      end
      if (r < 30) begin
        text_bytes[$urandom_range(0, n - 1)] = 8'(8'h61 + $urandom_range(0, alpha));
      end else if (r < 40 && n > 1) begin
        n--;
      end else if (r < 45) begin
        text_bytes[n] = 8'($urandom_range(0, 255));
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 49) == 0) load_word($urandom_range(1, 3), alpha, 1'b0);
      if (i > 0 && $urandom_range(0, 49) == 0) begin
        send_item(MODE_IGNORED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      send_item(MODE_TEXT, text_bytes[i], i == n - 1);
    end
  endtask

  // Result side: stall at random, with calm stretches.
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && !sink_calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_pause();
      end
      m_axis_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Check every result transaction as it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int alpha;
    int nw;
    int len;
    int r;
    bit wide;
    bit fill;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unused code, text on an empty dictionary, byte extremes,
    // a partly loaded word during a text, an overlong word, and a clear.
    send_item(MODE_IGNORED, 8'hFF, 1'b1);
    send_item(MODE_TEXT, 8'h00, 1'b1);
    send_item(MODE_DICT, 8'h00, 1'b1);
    send_item(MODE_DICT, 8'hFF, 1'b1);
    send_item(MODE_TEXT, 8'h00, 1'b0);
    send_item(MODE_TEXT, 8'hFF, 1'b0);
    send_item(MODE_TEXT, 8'h00, 1'b1);
    send_item(MODE_TEXT, 8'h7E, 1'b1);
    send_item(MODE_DICT, 8'h61, 1'b0);
    send_item(MODE_TEXT, 8'h61, 1'b1);
    send_item(MODE_DICT, 8'h62, 1'b1);
    send_item(MODE_TEXT, 8'h61, 1'b0);
    send_item(MODE_TEXT, 8'h62, 1'b0);
    send_item(MODE_TEXT, 8'hFF, 1'b1);
    for (int i = 0; i <= MAX_WORD_LEN; i++) begin
      send_item(MODE_DICT, 8'(8'h41 + i), i == MAX_WORD_LEN);
    end
    send_item(MODE_TEXT, 8'h61, 1'b0);
    send_item(MODE_TEXT, 8'h62, 1'b1);
    send_item(MODE_CLEAR, 8'h00, 1'b1);
    send_item(MODE_TEXT, 8'h61, 1'b1);
    vocab_n = 0;

    // Random phases: load a dictionary, then stream texts against it.
    while (items_sent < 2000) begin
      source_calm = ($urandom_range(0, 4) == 0);
      sink_calm   = ($urandom_range(0, 4) == 0);
      if (phase_count > 0 && $urandom_range(0, 4) != 0) begin
        send_item(MODE_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        vocab_n = 0;
      end
      alpha = $urandom_range(2, 4);
      wide  = ($urandom_range(0, 9) == 0);
      fill  = ($urandom_range(0, 9) == 0);
      if (fill) fill_phases++;
      nw = fill ? DICT_WORDS - vocab_n + $urandom_range(1, 4) : $urandom_range(1, 8);
      for (int w = 0; w < nw; w++) begin
        r = $urandom_range(0, 99);
        if (fill || r < 60) len = $urandom_range(1, 3);
        else if (r < 90) len = $urandom_range(4, 8);
        else if (r < 97) len = $urandom_range(9, MAX_WORD_LEN);
        else len = $urandom_range(MAX_WORD_LEN + 1, MAX_WORD_LEN + 4);
        load_word(len, alpha, wide);
      end
      repeat ($urandom_range(2, 6)) send_text(alpha);
      // Let the block run dry before the next phase now and then.
      if (phase_count == 2 || $urandom_range(0, 7) == 0) wait_results_drained();
      phase_count++;
    end

    wait_results_drained();
    repeat (DICT_WORDS + 16) @(posedge clk_i);
    if (sb.verdicts_due.size() != 0) begin
      sb.errors++;
      $error("%0d verdicts never arrived", sb.verdicts_due.size());
    end

    $display("Covered %0d transactions, %0d ignored codes, %0d phases, %0d table fills.",
             items_sent, ignored_sent, phase_count, fill_phases);
    $display("Checked %0d verdicts: %0d breakable, %0d flagged for a dropped word.",
             sb.verdicts_seen, sb.breakable_seen, sb.flagged_seen);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
